// File: rtl/mi4_pkg.sv
`default_nettype none

package mi4_pkg;

  // Fixed-point format and internal widths.
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  // A 3x3 minor is a sum of six triple products of 32-bit values.
  localparam int COF_W     = 97;
  // The determinant adds four products of an element and a cofactor.
  localparam int DET_W     = 132;
  // Long division words hold the divisor shifted past the quotient range.
  localparam int DIV_W     = DET_W + 34;
  localparam int Q_W       = 33;
  localparam int TERMS     = 6;

  localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic [Q_W-1:0]    Q_POS_MAX = Q_W'(SAT_POS);
  localparam logic [Q_W-1:0]    Q_NEG_MAX = Q_W'(SAT_NEG);

  // Status of the divider toward the sequencer.
  typedef struct packed {
    logic              done;
    logic              sat;
    logic [ELEM_W-1:0] value;
  } div_res_t;

  // Column taken from row i of a 3x3 minor in term t of its expansion.
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] i);
    logic [5:0] cols;
    logic [1:0] p;
    case (t)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = 6'd0;
    endcase
    case (i)
      2'd0:    p = cols[1:0];
      2'd1:    p = cols[3:2];
      2'd2:    p = cols[5:4];
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  // Storage address of factor i of term t for the cofactor at index k.
  // Cofactor k = 4r + c is the minor without row c and column r.
  function automatic logic [3:0] elem_addr(input logic [3:0] k, input logic [2:0] t,
                                           input logic [1:0] i);
    logic [1:0] row;
    logic [1:0] p;
    logic [1:0] col;
    row = (i < k[1:0]) ? i : i + 2'd1;
    p   = perm_col(t, i);
    col = (p < k[3:2]) ? p : p + 2'd1;
    return {row, col};
  endfunction

  // Term sign from the permutation, flipped by the cofactor's checkerboard sign.
  function automatic logic term_neg(input logic [3:0] k, input logic [2:0] t);
    logic odd_perm;
    odd_perm = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    return odd_perm ^ k[2] ^ k[0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/mi4_if.sv
`default_nettype none

// Channel carrying one matrix element per word.
interface mi4_elem_if
  import mi4_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

// Channel carrying one inverse element per word.
interface mi4_inv_if
  import mi4_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] inverse_value;
  logic              singular;
  logic              saturated;
  logic              last_element;

  modport source (output valid, output inverse_value, output singular,
                  output saturated, output last_element, input ready);
  modport sink   (input valid, input inverse_value, input singular,
                  input saturated, input last_element, output ready);
endinterface

`default_nettype wire

// File: rtl/mi4_div.sv
`default_nettype none

module mi4_div
  import mi4_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [COF_W-1:0] cof,
  input  wire logic [DET_W-1:0]        dmag,
  input  wire logic                    dneg,
  output div_res_t                     res
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_PREP = 4'b0010,
    D_CHK  = 4'b0100,
    D_STEP = 4'b1000
  } dstate_t;

  dstate_t           state;
  logic [COF_W-1:0]  cmag;
  logic              nneg;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [Q_W-1:0]    q;
  logic              big;
  logic [5:0]        cnt;
  logic              done;
  logic              neg;
  logic              over;
  logic              fits;

  // Sequencer: latch the magnitude, check the quotient range, then one bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) state <= D_PREP;
        end
        D_PREP: state <= D_CHK;
        D_CHK:  state <= D_STEP;
        D_STEP: begin
          if (cnt == 6'd0) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  // Restoring long division datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        if (start) begin
          nneg <= cof[COF_W-1];
          cmag <= cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
        end
      end
      D_PREP: begin
        rem <= DIV_W'(cmag) << (2 * FRAC_BITS);
        dsh <= DIV_W'(dmag) << Q_W;
      end
      D_CHK: begin
        big <= (rem >= dsh);
        dsh <= dsh >> 1;
        q   <= '0;
        cnt <= 6'(Q_W - 1);
      end
      D_STEP: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[Q_W-2:0], 1'b1};
        end else begin
          q   <= {q[Q_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 6'd1;
      end
      default: ;
    endcase
  end

  // Sign and clamp of the finished quotient.
  assign neg  = nneg ^ dneg;
  assign fits = neg ? (q <= Q_NEG_MAX) : (q <= Q_POS_MAX);
  assign over = big || !fits;

  assign res.done  = done;
  assign res.sat   = over;
  assign res.value = over ? (neg ? SAT_NEG : SAT_POS)
                          : (neg ? -q[ELEM_W-1:0] : q[ELEM_W-1:0]);

endmodule

`default_nettype wire

// File: rtl/matrix_inverse_4x4_top.sv
// 4x4 matrix inverse by cofactors and the adjugate, exact in fixed point.
// Input channel in_ch: one word per matrix element, signed Q16.16, storage
// order 0 to 15. Output channel out_ch: sixteen words per matrix, the inverse
// elements in storage order, with singular, saturated and last_element flags.
// Each inverse element is cofactor * 2^32 / determinant, truncated toward
// zero and clamped to 32 bits; a zero determinant gives sixteen zero words
// with singular set.
// Elements 0 to 15 are taken one per cycle. After the sixteenth, the block
// holds in_ch.ready low while it works: it sums the 6 terms of each of the
// 16 cofactors and writes each to memory, and adds each of the four
// cofactors of row 0 times its element into the determinant. Then the
// sixteen outputs are made one at a time by the bit-serial divider, which
// makes 33 quotient bits at one per cycle; a singular matrix skips the
// divider. Matrix elements and cofactors sit in two small synchronous
// memories with registered reads. A stalled receiver holds the output
// register and pauses the sequencer; loading of the next matrix starts as
// soon as the last word is in the output register. Reset returns to
// loading element 0.
`default_nettype none

module matrix_inverse_4x4_top
  import mi4_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mi4_elem_if.sink    in_ch,
  mi4_inv_if.source   out_ch
);

  typedef enum logic [9:0] {
    ST_LOAD   = 10'b00_0000_0001,
    ST_TERM   = 10'b00_0000_0010,
    ST_COFWR  = 10'b00_0000_0100,
    ST_DETM   = 10'b00_0000_1000,
    ST_DPREP  = 10'b00_0001_0000,
    ST_DRD    = 10'b00_0010_0000,
    ST_DSTART = 10'b00_0100_0000,
    ST_DWAIT  = 10'b00_1000_0000,
    ST_DOUT   = 10'b01_0000_0000,
    ST_SOUT   = 10'b10_0000_0000
  } state_t;

  state_t                    state;
  logic [3:0]                load_cnt;
  logic [3:0]                k;
  logic [2:0]                t;
  logic [2:0]                ustep;

  logic [ELEM_W-1:0]         mat_mem [16];
  logic [ELEM_W-1:0]         mat_rdata;
  logic [3:0]                mat_raddr;
  logic signed [COF_W-1:0]   cof_mem [16];
  logic signed [COF_W-1:0]   cof_rdata;

  logic signed [ELEM_W-1:0]  ra;
  logic signed [ELEM_W-1:0]  rc;
  logic signed [ELEM_W-1:0]  ph;
  logic signed [Q_W-1:0]     mul_x;
  logic signed [Q_W-1:0]     mul_y;
  logic signed [2*Q_W-1:0]   prod;
  logic signed [COF_W-1:0]   cof_acc;
  logic signed [COF_W-1:0]   term_add;
  logic signed [DET_W-1:0]   det_acc;
  logic [DET_W-1:0]          dmag;
  logic                      dneg;

  logic                      accept;
  logic                      out_free;
  logic                      div_start;
  div_res_t                  div_res;

  logic                      ov;
  logic [ELEM_W-1:0]         o_value;
  logic                      o_sing;
  logic                      o_sat;
  logic                      o_last;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !ov || out_ch.ready;
  assign in_ch.ready = (state == ST_LOAD);
  assign div_start = (state == ST_DSTART);

  // Element memory: written while loading, read by the cofactor sequencer.
  always_comb begin
    priority if (state == ST_TERM) mat_raddr = elem_addr(k, t, ustep[1:0]);
    else                           mat_raddr = {2'b00, k[3:2]};
  end

  always_ff @(posedge clk) begin
    if (accept) mat_mem[load_cnt] <= in_ch.element_value;
    mat_rdata <= mat_mem[mat_raddr];
  end

  // Cofactor memory: one entry per cofactor, read back for the division.
  always_ff @(posedge clk) begin
    if (state == ST_COFWR) cof_mem[k] <= cof_acc;
    cof_rdata <= cof_mem[k];
  end

  // Operand selection for the shared 33x33 multiplier.
  always_comb begin
    mul_x = Q_W'(ra);
    mul_y = Q_W'($signed(mat_rdata));
    priority if (state == ST_TERM && ustep == 3'd3) begin
      mul_x = {1'b0, prod[ELEM_W-1:0]};
    end else if (state == ST_TERM && ustep == 3'd4) begin
      mul_x = Q_W'(ph);
      mul_y = Q_W'(rc);
    end else if (state == ST_DETM && ustep == 3'd1) begin
      mul_y = {1'b0, cof_acc[ELEM_W-1:0]};
    end else if (state == ST_DETM && ustep == 3'd2) begin
      mul_y = {1'b0, cof_acc[2*ELEM_W-1:ELEM_W]};
    end else if (state == ST_DETM) begin
      mul_y = cof_acc[COF_W-1:2*ELEM_W];
    end else begin
      mul_y = Q_W'($signed(mat_rdata));
    end
  end

  // Low half of a triple product, or the high half shifted up by a word.
  assign term_add = (ustep == 3'd4) ? COF_W'(prod) : (COF_W'(prod) << ELEM_W);

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      load_cnt <= 4'd0;
      ov       <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            load_cnt <= load_cnt + 4'd1;
            if (load_cnt == 4'd15) begin
              state <= ST_TERM;
              k     <= 4'd0;
              t     <= 3'd0;
              ustep <= 3'd0;
            end
          end
        end
        ST_TERM: begin
          if (ustep == 3'd5) begin
            ustep <= 3'd0;
            if (t == 3'(TERMS - 1)) state <= ST_COFWR;
            else                    t     <= t + 3'd1;
          end else begin
            ustep <= ustep + 3'd1;
          end
        end
        ST_COFWR: begin
          ustep <= 3'd0;
          t     <= 3'd0;
          if (k[1:0] == 2'd0) begin
            state <= ST_DETM;
          end else if (k == 4'd15) begin
            state <= ST_DPREP;
          end else begin
            state <= ST_TERM;
            k     <= k + 4'd1;
          end
        end
        ST_DETM: begin
          if (ustep == 3'd4) begin
            ustep <= 3'd0;
            state <= ST_TERM;
            k     <= k + 4'd1;
          end else begin
            ustep <= ustep + 3'd1;
          end
        end
        ST_DPREP: begin
          k <= 4'd0;
          if (det_acc == '0) state <= ST_SOUT;
          else               state <= ST_DRD;
        end
        ST_DRD:    state <= ST_DSTART;
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_res.done) state <= ST_DOUT;
        end
        ST_DOUT: begin
          if (out_free) begin
            if (k == 4'd15) state <= ST_LOAD;
            else begin
              k     <= k + 4'd1;
              state <= ST_DRD;
            end
          end
        end
        ST_SOUT: begin
          if (out_free) begin
            if (k == 4'd15) state <= ST_LOAD;
            else            k     <= k + 4'd1;
          end
        end
        default: state <= ST_LOAD;
      endcase
      // Output valid: set when a word is loaded, cleared when it is taken.
      if ((state == ST_DOUT || state == ST_SOUT) && out_free) ov <= 1'b1;
      else if (out_ch.ready)                                  ov <= 1'b0;
    end
  end

  // Products, accumulators and determinant magnitude.
  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
    if (state == ST_LOAD) begin
      cof_acc <= '0;
      det_acc <= '0;
    end
    if (state == ST_TERM) begin
      unique case (ustep)
        3'd1: ra <= $signed(mat_rdata);
        3'd3: begin
          rc <= $signed(mat_rdata);
          ph <= prod[2*ELEM_W-1:ELEM_W];
        end
        3'd4, 3'd5: begin
          cof_acc <= term_neg(k, t) ? cof_acc - term_add : cof_acc + term_add;
        end
        default: ;
      endcase
    end
    if (state == ST_DETM) begin
      unique case (ustep)
        3'd0: ra <= $signed(mat_rdata);
        3'd2: det_acc <= det_acc + DET_W'(prod);
        3'd3: det_acc <= det_acc + (DET_W'(prod) << ELEM_W);
        3'd4: det_acc <= det_acc + (DET_W'(prod) << (2 * ELEM_W));
        default: ;
      endcase
      if (ustep == 3'd4) cof_acc <= '0;
    end
    if (state == ST_COFWR && k[1:0] != 2'd0) cof_acc <= '0;
    if (state == ST_DPREP) begin
      dneg <= det_acc[DET_W-1];
      dmag <= det_acc[DET_W-1] ? DET_W'(-det_acc) : DET_W'(det_acc);
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (state == ST_DOUT && out_free) begin
      o_value <= div_res.value;
      o_sat   <= div_res.sat;
      o_sing  <= 1'b0;
      o_last  <= (k == 4'd15);
    end else if (state == ST_SOUT && out_free) begin
      o_value <= '0;
      o_sat   <= 1'b0;
      o_sing  <= 1'b1;
      o_last  <= (k == 4'd15);
    end
  end

  mi4_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .cof   (cof_rdata),
    .dmag  (dmag),
    .dneg  (dneg),
    .res   (div_res)
  );

  assign out_ch.valid         = ov;
  assign out_ch.inverse_value = o_value;
  assign out_ch.singular      = o_sing;
  assign out_ch.saturated     = o_sat;
  assign out_ch.last_element  = o_last;

endmodule

`default_nettype wire

// File: rtl/mi4_checker.sv
`default_nettype none

module mi4_checker
  import mi4_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ELEM_W-1:0] out_value,
  input wire logic              out_singular,
  input wire logic              out_saturated,
  input wire logic              out_last
);

  // A stalled word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled word keeps its value and its last flag.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
    else $error("output word changed while stalled");

  // Singular words are zero and never clamped.
  a_sing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_singular |-> out_value == '0 && !out_saturated)
    else $error("singular word carries data");

  // A clamped word holds one of the two range limits.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_saturated |-> out_value == SAT_POS || out_value == SAT_NEG)
    else $error("saturated word is not a range limit");

endmodule

bind matrix_inverse_4x4_top mi4_checker u_mi4_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value     (out_ch.inverse_value),
  .out_singular  (out_ch.singular),
  .out_saturated (out_ch.saturated),
  .out_last      (out_ch.last_element)
);

`default_nettype wire
